/* rtl/mpcpmb_pkg.sv */
// Shared types, codes and Q16.16 arithmetic for the prediction matrix builder.
// No dependencies; every other file except mpcpmb_ram imports this package.
`default_nettype none
package mpcpmb_pkg;

    localparam int DEF_MAX_HORIZON = 16;
    localparam int DEF_MAX_STATE   = 8;
    localparam int DEF_MAX_INPUT   = 4;

    localparam logic [2:0] KIND_LOAD_A  = 3'd0;
    localparam logic [2:0] KIND_LOAD_B  = 3'd1;
    localparam logic [2:0] KIND_COMPUTE = 3'd2;
    localparam logic [2:0] KIND_READ_S  = 3'd3;
    localparam logic [2:0] KIND_READ_T  = 3'd4;

    localparam logic [1:0] CFG_HORIZON = 2'd0;
    localparam logic [1:0] CFG_STATE   = 2'd1;
    localparam logic [1:0] CFG_INPUT   = 2'd2;

    localparam logic [4:0] RST_HORIZON = 5'd16;
    localparam logic [3:0] RST_STATE   = 4'd8;
    localparam logic [2:0] RST_INPUT   = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic accept_ld;
        logic rd_item;
        logic cp;
        logic use_s;
        logic start;
        logic elem_adv;
        logic k_inc;
        logic k_clr;
        logic prod_ld;
        logic acc_ld;
        logic acc_clr;
        logic i_clr;
        logic i_inc;
        logic j_from_i;
        logic j_inc;
        logic t_we;
        logic s_we;
        logic out_rd;
        logic out_done;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last_c;
        logic last_r;
        logic last_k;
        logic last_i;
        logic last_j;
        logic out_free;
    } t_stat;

    // round a Q32.32 product to Q16.16, ties up; returns {saturated, value}
    function automatic logic [32:0] f_qround(input logic signed [63:0] p);
        logic signed [63:0] q;
        q = (p + 64'sd32768) >>> 16;
        if (q > 64'sd2147483647) begin
            return {1'b1, 32'h7fff_ffff};
        end else if (q < -64'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, q[31:0]};
    endfunction

    // saturating add; returns {saturated, value}
    function automatic logic [32:0] f_qadd(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return {1'b1, s[32] ? 32'h8000_0000 : 32'h7fff_ffff};
        end
        return {1'b0, s[31:0]};
    endfunction

endpackage
`default_nettype wire

/* rtl/mpcpmb_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module mpcpmb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/mpcpmb_dpath.sv */
// Datapath: A/B/T/S memories, loop counters, multiply-accumulate, output word.
// Depends on mpcpmb_pkg and mpcpmb_ram.
`default_nettype none
module mpcpmb_dpath import mpcpmb_pkg::*; #(
    parameter int MAX_HORIZON = DEF_MAX_HORIZON,
    parameter int MAX_STATE   = DEF_MAX_STATE,
    parameter int MAX_INPUT   = DEF_MAX_INPUT,
    localparam int NHW = $clog2(MAX_HORIZON + 1),
    localparam int NSW = $clog2(MAX_STATE + 1),
    localparam int NIW = $clog2(MAX_INPUT + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    input  wire logic [NHW-1:0]        i_nh,
    input  wire logic [NSW-1:0]        i_ns,
    input  wire logic [NIW-1:0]        i_ni,
    input  wire logic [2:0]            i_kind,
    input  wire logic [3:0]            i_step_index,
    input  wire logic [3:0]            i_block_col,
    input  wire logic [2:0]            i_elem_row,
    input  wire logic [2:0]            i_elem_col,
    input  wire logic signed [31:0]    i_elem_value,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic signed [31:0]         o_read_value,
    output logic                       o_compute_done,
    output logic                       o_saturated
);
    localparam int DA  = MAX_HORIZON * MAX_STATE * MAX_STATE;
    localparam int DB  = MAX_HORIZON * MAX_STATE * MAX_INPUT;
    localparam int DS  = MAX_HORIZON * MAX_HORIZON * MAX_STATE * MAX_INPUT;
    localparam int AAW = (DA > 1) ? $clog2(DA) : 1;
    localparam int BAW = (DB > 1) ? $clog2(DB) : 1;
    localparam int SAW = (DS > 1) ? $clog2(DS) : 1;
    localparam int HW  = (MAX_HORIZON > 1) ? $clog2(MAX_HORIZON) : 1;
    localparam int SW  = (MAX_STATE > 1) ? $clog2(MAX_STATE) : 1;
    localparam int MC  = (MAX_STATE > MAX_INPUT) ? MAX_STATE : MAX_INPUT;
    localparam int CW  = (MC > 1) ? $clog2(MC) : 1;

    function automatic logic [AAW-1:0] f_a_addr(input logic [31:0] k,
                                                 input logic [31:0] r,
                                                 input logic [31:0] c);
        return AAW'((k * MAX_STATE + r) * MAX_STATE + c);
    endfunction

    function automatic logic [BAW-1:0] f_b_addr(input logic [31:0] k,
                                                 input logic [31:0] r,
                                                 input logic [31:0] c);
        return BAW'((k * MAX_STATE + r) * MAX_INPUT + c);
    endfunction

    function automatic logic [SAW-1:0] f_s_addr(input logic [31:0] j,
                                                 input logic [31:0] i,
                                                 input logic [31:0] r,
                                                 input logic [31:0] c);
        return SAW'(((j * MAX_HORIZON + i) * MAX_STATE + r) * MAX_INPUT + c);
    endfunction

    // latched item
    logic [2:0] r_kind;
    logic [3:0] r_step;
    logic [3:0] r_bcol;
    logic [2:0] r_row;
    logic [2:0] r_col;

    // loop counters
    logic [HW-1:0] r_i, r_j;
    logic [SW-1:0] r_r, r_k;
    logic [CW-1:0] r_c;

    logic signed [63:0] r_prod;
    logic signed [31:0] r_acc;
    logic               r_ovf;

    logic signed [31:0] r_out_value;
    logic               r_out_done;
    logic               r_out_sat;
    logic               r_out_valid;

    logic [31:0] lim_c;
    logic        t_ok, s_ok;
    logic        a_we, b_we;
    logic [AAW-1:0] a_waddr, a_raddr, t_waddr, t_raddr;
    logic [BAW-1:0] b_waddr, b_raddr;
    logic [SAW-1:0] s_waddr, s_raddr;
    logic [31:0] a_rdata, b_rdata, t_rdata, s_rdata, t_wdata, s_wdata;
    logic [31:0] mul_b;
    logic [32:0] rnd, sum;

    assign lim_c = i_cmd.use_s ? 32'(i_ni) : 32'(i_ns);

    assign o_stat.last_c   = (32'(r_c) == lim_c - 32'd1);
    assign o_stat.last_r   = (32'(r_r) == 32'(i_ns) - 32'd1);
    assign o_stat.last_k   = (32'(r_k) == 32'(i_ns) - 32'd1);
    assign o_stat.last_i   = (32'(r_i) == 32'(i_nh) - 32'd1);
    assign o_stat.last_j   = (32'(r_j) == 32'(i_nh) - 32'd1);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign t_ok = (32'(r_step) < 32'(i_nh)) && (32'(r_row) < 32'(i_ns))
               && (32'(r_col) < 32'(i_ns));
    assign s_ok = (32'(r_step) < 32'(i_nh)) && (32'(r_bcol) < 32'(i_nh))
               && (r_bcol <= r_step) && (32'(r_row) < 32'(i_ns))
               && (32'(r_col) < 32'(i_ni));

    assign a_we = i_cmd.accept_ld && (i_kind == KIND_LOAD_A)
               && (32'(i_step_index) < MAX_HORIZON)
               && (32'(i_elem_row) < MAX_STATE) && (32'(i_elem_col) < MAX_STATE);
    assign b_we = i_cmd.accept_ld && (i_kind == KIND_LOAD_B)
               && (32'(i_step_index) < MAX_HORIZON)
               && (32'(i_elem_row) < MAX_STATE) && (32'(i_elem_col) < MAX_INPUT);

    assign a_waddr = f_a_addr(32'(i_step_index), 32'(i_elem_row), 32'(i_elem_col));
    assign b_waddr = f_b_addr(32'(i_step_index), 32'(i_elem_row), 32'(i_elem_col));

    always_comb begin
        if (i_cmd.cp) begin
            a_raddr = f_a_addr(32'd0, 32'(r_r), 32'(r_c));
        end else begin
            a_raddr = f_a_addr(i_cmd.use_s ? 32'(r_j) : 32'(r_i), 32'(r_r), 32'(r_k));
        end
        if (i_cmd.rd_item) begin
            t_raddr = t_ok ? f_a_addr(32'(r_step), 32'(r_row), 32'(r_col)) : '0;
            s_raddr = s_ok ? f_s_addr(32'(r_step), 32'(r_bcol), 32'(r_row), 32'(r_col))
                           : '0;
        end else begin
            t_raddr = f_a_addr(32'(r_i) - 32'd1, 32'(r_k), 32'(r_c));
            s_raddr = f_s_addr(32'(r_j) - 32'd1, 32'(r_i), 32'(r_k), 32'(r_c));
        end
        b_raddr = f_b_addr(32'(r_i), 32'(r_r), 32'(r_c));
        t_waddr = f_a_addr(32'(r_i), 32'(r_r), 32'(r_c));
        s_waddr = f_s_addr(i_cmd.cp ? 32'(r_i) : 32'(r_j), 32'(r_i), 32'(r_r), 32'(r_c));
        t_wdata = i_cmd.cp ? a_rdata : r_acc;
        s_wdata = i_cmd.cp ? b_rdata : r_acc;
    end

    mpcpmb_ram #(.WIDTH(32), .DEPTH(DA)) u_a_ram (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(i_elem_value),
        .i_raddr(a_raddr), .o_rdata(a_rdata)
    );
    mpcpmb_ram #(.WIDTH(32), .DEPTH(DB)) u_b_ram (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(i_elem_value),
        .i_raddr(b_raddr), .o_rdata(b_rdata)
    );
    mpcpmb_ram #(.WIDTH(32), .DEPTH(DA)) u_t_ram (
        .i_clk(i_clk), .i_we(i_cmd.t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(t_raddr), .o_rdata(t_rdata)
    );
    mpcpmb_ram #(.WIDTH(32), .DEPTH(DS)) u_s_ram (
        .i_clk(i_clk), .i_we(i_cmd.s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    assign mul_b = i_cmd.use_s ? s_rdata : t_rdata;
    assign rnd   = f_qround(r_prod);
    assign sum   = f_qadd(r_acc, rnd[31:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_ld) begin
            r_kind <= i_kind;
            r_step <= i_step_index;
            r_bcol <= i_block_col;
            r_row  <= i_elem_row;
            r_col  <= i_elem_col;
        end
        if (i_cmd.prod_ld) begin
            r_prod <= $signed(a_rdata) * $signed(mul_b);
        end
        if (i_cmd.start || i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_ld) begin
            r_acc <= sum[31:0];
        end
        // hold the flag with the word so a later compute cannot change it
        if (i_cmd.out_rd) begin
            if (r_kind == KIND_READ_S) begin
                r_out_value <= s_ok ? s_rdata : '0;
            end else begin
                r_out_value <= t_ok ? t_rdata : '0;
            end
            r_out_done <= 1'b0;
            r_out_sat  <= r_ovf;
        end else if (i_cmd.out_done) begin
            r_out_value <= '0;
            r_out_done  <= 1'b1;
            r_out_sat   <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
            r_r <= '0;
            r_c <= '0;
            r_k <= '0;
            r_ovf <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_i <= '0;
                r_j <= '0;
                r_r <= '0;
                r_c <= '0;
                r_k <= '0;
                r_ovf <= 1'b0;
            end else begin
                if (i_cmd.elem_adv) begin
                    if (o_stat.last_c) begin
                        r_c <= '0;
                        r_r <= o_stat.last_r ? '0 : r_r + SW'(1);
                    end else begin
                        r_c <= r_c + CW'(1);
                    end
                end
                if (i_cmd.k_clr) begin
                    r_k <= '0;
                end else if (i_cmd.k_inc) begin
                    r_k <= r_k + SW'(1);
                end
                if (i_cmd.i_clr) begin
                    r_i <= '0;
                end else if (i_cmd.i_inc) begin
                    r_i <= r_i + HW'(1);
                end
                if (i_cmd.j_from_i) begin
                    r_j <= r_i + HW'(1);
                end else if (i_cmd.j_inc) begin
                    r_j <= r_j + HW'(1);
                end
                if (i_cmd.acc_ld && (rnd[32] || sum[32])) begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.out_rd || i_cmd.out_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_value   = r_out_value;
    assign o_compute_done = r_out_done;
    assign o_saturated    = r_out_sat;
endmodule
`default_nettype wire

/* rtl/mpcpmb_ctrl.sv */
// Controller: sequences loads, reads and the compute pass over the datapath.
// Depends on mpcpmb_pkg.
`default_nettype none
module mpcpmb_ctrl import mpcpmb_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [2:0] i_kind,
    input  wire t_stat      i_stat,
    output t_cmd            o_cmd
);
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_RD_ADDR = 4'd1;
    localparam logic [3:0] ST_RD_OUT  = 4'd2;
    localparam logic [3:0] ST_TC_RD   = 4'd3;
    localparam logic [3:0] ST_TC_WR   = 4'd4;
    localparam logic [3:0] ST_SC_RD   = 4'd5;
    localparam logic [3:0] ST_SC_WR   = 4'd6;
    localparam logic [3:0] ST_M_RD    = 4'd7;
    localparam logic [3:0] ST_M_MUL   = 4'd8;
    localparam logic [3:0] ST_M_ACC   = 4'd9;
    localparam logic [3:0] ST_M_WR    = 4'd10;
    localparam logic [3:0] ST_DONE    = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_phase_s, n_phase_s;
    logic       accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_phase_s = r_phase_s;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept_ld = accept;
                if (accept) begin
                    if (i_kind == KIND_COMPUTE) begin
                        o_cmd.start = 1'b1;
                        n_state = ST_TC_RD;
                    end else if (i_kind == KIND_READ_S || i_kind == KIND_READ_T) begin
                        n_state = ST_RD_ADDR;
                    end
                end
            end
            ST_RD_ADDR: begin
                o_cmd.rd_item = 1'b1;
                n_state = ST_RD_OUT;
            end
            ST_RD_OUT: begin
                o_cmd.rd_item = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.out_rd = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_TC_RD: begin
                o_cmd.cp = 1'b1;
                n_state = ST_TC_WR;
            end
            ST_TC_WR: begin
                o_cmd.cp = 1'b1;
                o_cmd.t_we = 1'b1;
                o_cmd.elem_adv = 1'b1;
                if (i_stat.last_r && i_stat.last_c) begin
                    n_phase_s = 1'b0;
                    if (i_stat.last_i) begin
                        o_cmd.i_clr = 1'b1;
                        n_state = ST_SC_RD;
                    end else begin
                        o_cmd.i_inc = 1'b1;
                        n_state = ST_M_RD;
                    end
                end else begin
                    n_state = ST_TC_RD;
                end
            end
            ST_SC_RD: begin
                o_cmd.cp = 1'b1;
                o_cmd.use_s = 1'b1;
                n_state = ST_SC_WR;
            end
            ST_SC_WR: begin
                o_cmd.cp = 1'b1;
                o_cmd.use_s = 1'b1;
                o_cmd.s_we = 1'b1;
                o_cmd.elem_adv = 1'b1;
                if (i_stat.last_r && i_stat.last_c) begin
                    if (i_stat.last_i) begin
                        n_state = ST_DONE;
                    end else begin
                        o_cmd.j_from_i = 1'b1;
                        n_phase_s = 1'b1;
                        n_state = ST_M_RD;
                    end
                end else begin
                    n_state = ST_SC_RD;
                end
            end
            ST_M_RD: begin
                o_cmd.use_s = r_phase_s;
                n_state = ST_M_MUL;
            end
            ST_M_MUL: begin
                o_cmd.use_s = r_phase_s;
                o_cmd.prod_ld = 1'b1;
                n_state = ST_M_ACC;
            end
            ST_M_ACC: begin
                o_cmd.use_s = r_phase_s;
                o_cmd.acc_ld = 1'b1;
                if (i_stat.last_k) begin
                    n_state = ST_M_WR;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = ST_M_RD;
                end
            end
            ST_M_WR: begin
                o_cmd.use_s = r_phase_s;
                o_cmd.s_we = r_phase_s;
                o_cmd.t_we = !r_phase_s;
                o_cmd.elem_adv = 1'b1;
                o_cmd.k_clr = 1'b1;
                o_cmd.acc_clr = 1'b1;
                n_state = ST_M_RD;
                if (i_stat.last_r && i_stat.last_c) begin
                    if (!r_phase_s) begin
                        if (i_stat.last_i) begin
                            o_cmd.i_clr = 1'b1;
                            n_state = ST_SC_RD;
                        end else begin
                            o_cmd.i_inc = 1'b1;
                        end
                    end else if (i_stat.last_j) begin
                        // block column done: copy the next diagonal block
                        o_cmd.i_inc = 1'b1;
                        n_state = ST_SC_RD;
                    end else begin
                        o_cmd.j_inc = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_done = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase_s <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase_s <= n_phase_s;
        end
    end

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.t_we && o_cmd.s_we))
        else $error("T and S written together");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_rd || o_cmd.out_done) |-> i_stat.out_free)
        else $error("output word overwritten");
    a_compute_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == KIND_COMPUTE) |=> (r_state == ST_TC_RD))
        else $error("compute did not start");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_cmd.accept_ld)
        else $error("item latched while busy");
endmodule
`default_nettype wire

/* rtl/mpc_prediction_matrix_builder_core.sv */
// Load item: written on accept. Read item: states ST_RD_ADDR, then ST_RD_OUT, which
// registers the result word; the next item is taken back in idle. A result word still
// waiting holds back only the next read or compute. Compute: a read and a write state
// per copied element; per product element a read, multiply and accumulate state per
// term, then a write state (one MAC unit, one read port per memory); then the done word.
// Reset is synchronous, active low: config back to 16/8/4, flag cleared; memories hold.
`default_nettype none
module mpc_prediction_matrix_builder_core import mpcpmb_pkg::*; #(
    parameter int MAX_HORIZON = DEF_MAX_HORIZON,
    parameter int MAX_STATE   = DEF_MAX_STATE,
    parameter int MAX_INPUT   = DEF_MAX_INPUT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [4:0]         i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [2:0]         i_kind,
    input  wire logic [3:0]         i_step_index,
    input  wire logic [3:0]         i_block_col,
    input  wire logic [2:0]         i_elem_row,
    input  wire logic [2:0]         i_elem_col,
    input  wire logic signed [31:0] i_elem_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_read_value,
    output logic                    o_compute_done,
    output logic                    o_saturated
);
    localparam int NHW = $clog2(MAX_HORIZON + 1);
    localparam int NSW = $clog2(MAX_STATE + 1);
    localparam int NIW = $clog2(MAX_INPUT + 1);

    logic [4:0] r_horizon;
    logic [3:0] r_state_dim;
    logic [2:0] r_input_dim;
    logic [NHW-1:0] nh;
    logic [NSW-1:0] ns;
    logic [NIW-1:0] ni;
    t_cmd  cmd;
    t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_horizon   <= RST_HORIZON;
            r_state_dim <= RST_STATE;
            r_input_dim <= RST_INPUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HORIZON: r_horizon   <= i_cfg_data;
                CFG_STATE:   r_state_dim <= i_cfg_data[3:0];
                CFG_INPUT:   r_input_dim <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // clamp each register into its usable range
    always_comb begin
        if (r_horizon == '0) nh = NHW'(1);
        else if (32'(r_horizon) > MAX_HORIZON) nh = NHW'(MAX_HORIZON);
        else nh = NHW'(r_horizon);
        if (r_state_dim == '0) ns = NSW'(1);
        else if (32'(r_state_dim) > MAX_STATE) ns = NSW'(MAX_STATE);
        else ns = NSW'(r_state_dim);
        if (r_input_dim == '0) ni = NIW'(1);
        else if (32'(r_input_dim) > MAX_INPUT) ni = NIW'(MAX_INPUT);
        else ni = NIW'(r_input_dim);
    end

    mpcpmb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_kind(i_kind), .i_stat(stat), .o_cmd(cmd)
    );

    mpcpmb_dpath #(
        .MAX_HORIZON(MAX_HORIZON), .MAX_STATE(MAX_STATE), .MAX_INPUT(MAX_INPUT)
    ) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_nh(nh), .i_ns(ns), .i_ni(ni),
        .i_kind(i_kind), .i_step_index(i_step_index), .i_block_col(i_block_col),
        .i_elem_row(i_elem_row), .i_elem_col(i_elem_col), .i_elem_value(i_elem_value),
        .i_out_ready(i_out_ready), .o_out_valid(o_out_valid),
        .o_read_value(o_read_value), .o_compute_done(o_compute_done),
        .o_saturated(o_saturated)
    );
endmodule
`default_nettype wire

/* tb/sv/mpcpmb_matrix_checker.sv */
// Checker for the prediction matrix builder: mirrors the A/B/S/T stores and the
// config registers, predicts every result word and compares it. Uses mpcpmb_pkg codes.
`default_nettype none
module mpcpmb_matrix_checker import mpcpmb_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [4:0]         i_cfg_data,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic [2:0]         i_kind,
    input  wire logic [3:0]         i_step_index,
    input  wire logic [3:0]         i_block_col,
    input  wire logic [2:0]         i_elem_row,
    input  wire logic [2:0]         i_elem_col,
    input  wire logic signed [31:0] i_elem_value,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic signed [31:0] i_read_value,
    input  wire logic               i_compute_done,
    input  wire logic               i_saturated,
    output int                      o_errors,
    output int                      o_pending,
    output int                      o_reads,
    output int                      o_computes,
    output int                      o_sat_words
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] value;
        logic               done;
        logic               sat;
    } t_word;

    logic [4:0] horizon_reg;
    logic [3:0] state_reg;
    logic [2:0] input_reg;
    logic       overflow_flag;

    logic signed [31:0] a_mem [1024];
    logic signed [31:0] b_mem [512];
    logic signed [31:0] t_mem [1024];
    logic signed [31:0] s_mem [8192];

    t_word expected_words [$];

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_reads = 0;
        o_computes = 0;
        o_sat_words = 0;
        foreach (a_mem[n]) a_mem[n] = '0;
        foreach (b_mem[n]) b_mem[n] = '0;
        foreach (t_mem[n]) t_mem[n] = '0;
        foreach (s_mem[n]) s_mem[n] = '0;
    end

    function automatic int clamp_dim(input int v, input int hi);
        return (v < 1) ? 1 : (v > hi) ? hi : v;
    endfunction

    function automatic int a_at(input int k, input int r, input int c);
        return (k * 8 + r) * 8 + c;
    endfunction

    function automatic int b_at(input int k, input int r, input int c);
        return (k * 8 + r) * 4 + c;
    endfunction

    function automatic int s_at(input int j, input int i, input int r, input int c);
        return ((j * 16 + i) * 8 + r) * 4 + c;
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            overflow_flag = 1'b1;
            return 32'sh7fff_ffff;
        end
        if (v < -64'sd2147483648) begin
            overflow_flag = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Q16.16 product: add half an LSB, then floor (arithmetic shift)
    function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd32768;
        return clip32(p >>> 16);
    endfunction

    function automatic logic signed [31:0] q_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return clip32(64'(a) + 64'(b));
    endfunction

    task automatic build_prediction_matrices();
        int nh, ns, ni;
        logic signed [31:0] acc;
        nh = clamp_dim(horizon_reg, 16);
        ns = clamp_dim(state_reg, 8);
        ni = clamp_dim(input_reg, 4);
        overflow_flag = 1'b0;
        for (int r = 0; r < ns; r++)
            for (int c = 0; c < ns; c++)
                t_mem[a_at(0, r, c)] = a_mem[a_at(0, r, c)];
        for (int i = 1; i < nh; i++)
            for (int r = 0; r < ns; r++)
                for (int c = 0; c < ns; c++) begin
                    acc = '0;
                    for (int k = 0; k < ns; k++)
                        acc = q_add(acc, q_mul(a_mem[a_at(i, r, k)], t_mem[a_at(i - 1, k, c)]));
                    t_mem[a_at(i, r, c)] = acc;
                end
        for (int i = 0; i < nh; i++) begin
            for (int r = 0; r < ns; r++)
                for (int c = 0; c < ni; c++)
                    s_mem[s_at(i, i, r, c)] = b_mem[b_at(i, r, c)];
            for (int j = i + 1; j < nh; j++)
                for (int r = 0; r < ns; r++)
                    for (int c = 0; c < ni; c++) begin
                        acc = '0;
                        for (int k = 0; k < ns; k++)
                            acc = q_add(acc, q_mul(a_mem[a_at(j, r, k)],
                                                   s_mem[s_at(j - 1, i, k, c)]));
                        s_mem[s_at(j, i, r, c)] = acc;
                    end
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        int nh, ns, ni;
        t_word w;
        if (!i_rst_n) begin
            horizon_reg = RST_HORIZON;
            state_reg = RST_STATE;
            input_reg = RST_INPUT;
            overflow_flag = 1'b0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HORIZON: horizon_reg = i_cfg_data;
                    CFG_STATE:   state_reg = i_cfg_data[3:0];
                    CFG_INPUT:   input_reg = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                nh = clamp_dim(horizon_reg, 16);
                ns = clamp_dim(state_reg, 8);
                ni = clamp_dim(input_reg, 4);
                w = '0;
                case (i_kind)
                    KIND_LOAD_A: a_mem[a_at(i_step_index, i_elem_row, i_elem_col)] = i_elem_value;
                    KIND_LOAD_B: begin
                        // columns past the physical input width are dropped
                        if (i_elem_col < 4)
                            b_mem[b_at(i_step_index, i_elem_row, i_elem_col)] = i_elem_value;
                    end
                    KIND_COMPUTE: begin
                        build_prediction_matrices();
                        w.done = 1'b1;
                        w.sat = overflow_flag;
                        expected_words.push_back(w);
                    end
                    KIND_READ_S: begin
                        if (i_step_index < nh && i_block_col <= i_step_index
                            && i_elem_row < ns && i_elem_col < ni)
                            w.value = s_mem[s_at(i_step_index, i_block_col, i_elem_row,
                                                 i_elem_col)];
                        w.sat = overflow_flag;
                        expected_words.push_back(w);
                    end
                    KIND_READ_T: begin
                        if (i_step_index < nh && i_elem_row < ns && i_elem_col < ns)
                            w.value = t_mem[a_at(i_step_index, i_elem_row, i_elem_col)];
                        w.sat = overflow_flag;
                        expected_words.push_back(w);
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with nothing expected", $realtime);
                    o_errors++;
                end else begin
                    w = expected_words.pop_front();
                    if (i_read_value !== w.value) report("read_value", i_read_value, w.value);
                    if (i_compute_done !== w.done) report("compute_done", i_compute_done, w.done);
                    if (i_saturated !== w.sat) report("saturated", i_saturated, w.sat);
                    if (w.done) o_computes++;
                    else o_reads++;
                    if (w.sat) o_sat_words++;
                end
            end
        end
        o_pending <= expected_words.size();
    end

endmodule
`default_nettype wire

/* tb/sv/tb_mpc_prediction_matrix_builder_core.sv */
// Testbench top for the prediction matrix builder: clock, reset, config writes and
// item stimulus; depends on mpcpmb_pkg, the core and mpcpmb_matrix_checker.
`default_nettype none
module tb_mpc_prediction_matrix_builder_core;
    import mpcpmb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [4:0]         i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [2:0]         i_kind = '0;
    logic [3:0]         i_step_index = '0;
    logic [3:0]         i_block_col = '0;
    logic [2:0]         i_elem_row = '0;
    logic [2:0]         i_elem_col = '0;
    logic signed [31:0] i_elem_value = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_read_value;
    logic               o_compute_done;
    logic               o_saturated;

    int errors, pending, reads, computes, sat_words;
    int items_sent = 0;
    int burst_left = 0;
    int cur_h, cur_s, cur_i;
    bit a_loaded [1024];
    bit b_loaded [512];

    mpc_prediction_matrix_builder_core dut (.*);

    mpcpmb_matrix_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_kind, .i_step_index, .i_block_col,
        .i_elem_row, .i_elem_col, .i_elem_value,
        .i_out_valid(o_out_valid), .i_out_ready, .i_read_value(o_read_value),
        .i_compute_done(o_compute_done), .i_saturated(o_saturated),
        .o_errors(errors), .o_pending(pending), .o_reads(reads),
        .o_computes(computes), .o_sat_words(sat_words)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: stall mode is redrawn at random: always ready, ready half or a quarter of the time
    int rx_cycle = 0;
    int rx_mode = 0;
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 2);
        case (rx_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 1) == 1);
            default: i_out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    initial begin
        #50_000_000;
        $display("timeout with %0d words still expected", pending);
        $display("** mpc_prediction_matrix_builder_core: FAILED **");
        $finish;
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return 32'(int'($urandom_range(0, 262144)) - 131072);
        endcase
    endfunction

    task automatic send(input logic [2:0] k, input logic [3:0] st, input logic [3:0] bc,
                        input logic [2:0] r, input logic [2:0] c, input logic [31:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_kind <= k;
        i_step_index <= st;
        i_block_col <= bc;
        i_elem_row <= r;
        i_elem_col <= c;
        i_elem_value <= v;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (k == KIND_LOAD_A) a_loaded[(st * 8 + r) * 8 + c] = 1'b1;
        if (k == KIND_LOAD_B && c < 4) b_loaded[(st * 8 + r) * 4 + c] = 1'b1;
    endtask

    // hold until every expected word is back, plus a margin for trailing loads
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_dims(input int h, input int s, input int n);
        drain();
        write_reg(CFG_HORIZON, 5'(h));
        write_reg(CFG_STATE, 5'(s));
        write_reg(CFG_INPUT, 5'(n));
        cur_h = (h < 1) ? 1 : (h > 16) ? 16 : h;
        cur_s = (s < 1) ? 1 : (s > 8) ? 8 : s;
        cur_i = (n < 1) ? 1 : (n > 4) ? 4 : n;
    endtask

    // load each A/B element the next compute will touch that is not loaded yet, then compute
    task automatic fill_and_compute();
        for (int k = 0; k < cur_h; k++)
            for (int r = 0; r < cur_s; r++) begin
                for (int c = 0; c < cur_s; c++)
                    if (!a_loaded[(k * 8 + r) * 8 + c])
                        send(KIND_LOAD_A, 4'(k), 4'($urandom), 3'(r), 3'(c), pick_value());
                for (int c = 0; c < cur_i; c++)
                    if (!b_loaded[(k * 8 + r) * 4 + c])
                        send(KIND_LOAD_B, 4'(k), 4'($urandom), 3'(r), 3'(c), pick_value());
            end
        send(KIND_COMPUTE, 4'($urandom), 4'($urandom), 3'($urandom), 3'($urandom), $urandom);
    endtask

    task automatic random_items(input int count, input bit may_compute);
        int sel, st, bc;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            // bias reads toward the live block range
            st = ($urandom_range(0, 3) != 0) ? $urandom_range(0, cur_h - 1) : $urandom_range(0, 15);
            bc = ($urandom_range(0, 3) != 0) ? $urandom_range(0, st) : $urandom_range(0, 15);
            if (sel < 30)
                send(KIND_LOAD_A, 4'($urandom), 4'($urandom), 3'($urandom), 3'($urandom),
                     pick_value());
            else if (sel < 45)
                send(KIND_LOAD_B, 4'($urandom), 4'($urandom), 3'($urandom), 3'($urandom),
                     pick_value());
            else if (sel < 70)
                send(KIND_READ_S, 4'(st), 4'(bc), 3'($urandom_range(0, cur_s)),
                     3'($urandom_range(0, cur_i)), $urandom);
            else if (sel < 88)
                send(KIND_READ_T, 4'(st), 4'($urandom), 3'($urandom_range(0, cur_s)),
                     3'($urandom_range(0, cur_s)), $urandom);
            else if (sel < 95 && may_compute)
                fill_and_compute();
            else
                send(3'($urandom_range(5, 7)), 4'($urandom), 4'($urandom), 3'($urandom),
                     3'($urandom), $urandom);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: small 2x2 system, saturation, every read corner, ignored items
        set_dims(2, 2, 2);
        fill_and_compute();
        send(KIND_LOAD_A, 4'd0, 4'd0, 3'd0, 3'd0, 32'h7fff_ffff);
        send(KIND_LOAD_A, 4'd1, 4'd0, 3'd0, 3'd0, 32'h8000_0000);
        send(KIND_LOAD_A, 4'd1, 4'd0, 3'd1, 3'd1, 32'h7fff_ffff);
        send(KIND_LOAD_A, 4'd15, 4'd0, 3'd7, 3'd7, 32'h0001_0000);
        send(KIND_LOAD_B, 4'd0, 4'd0, 3'd1, 3'd7, 32'h1234_5678);
        send(KIND_COMPUTE, 4'd0, 4'd0, 3'd0, 3'd0, 32'h0);
        send(KIND_READ_T, 4'd1, 4'd0, 3'd0, 3'd0, 32'h0);
        send(KIND_READ_T, 4'd1, 4'd0, 3'd1, 3'd1, 32'h0);
        send(KIND_READ_T, 4'd0, 4'd0, 3'd2, 3'd0, 32'h0);
        send(KIND_READ_T, 4'd0, 4'd0, 3'd0, 3'd7, 32'h0);
        send(KIND_READ_T, 4'd2, 4'd0, 3'd0, 3'd0, 32'h0);
        send(KIND_READ_S, 4'd0, 4'd0, 3'd1, 3'd1, 32'h0);
        send(KIND_READ_S, 4'd1, 4'd0, 3'd0, 3'd0, 32'h0);
        send(KIND_READ_S, 4'd1, 4'd1, 3'd1, 3'd0, 32'h0);
        send(KIND_READ_S, 4'd0, 4'd1, 3'd0, 3'd0, 32'h0);
        send(KIND_READ_S, 4'd15, 4'd15, 3'd7, 3'd7, 32'hffff_ffff);
        send(KIND_READ_S, 4'd1, 4'd0, 3'd0, 3'd2, 32'h0);
        send(3'd5, 4'd0, 4'd0, 3'd0, 3'd0, 32'h0);
        send(3'd6, 4'd15, 4'd15, 3'd7, 3'd7, 32'hffff_ffff);
        send(3'd7, 4'd0, 4'd0, 3'd0, 3'd0, 32'h0);
        random_items(60, 1'b1);

        // longest horizon and widest blocks, register values past either end of range
        set_dims(31, 1, 1);
        fill_and_compute();
        random_items(60, 1'b0);
        set_dims(0, 0, 0);
        fill_and_compute();
        random_items(60, 1'b1);
        set_dims(1, 15, 7);
        fill_and_compute();
        random_items(40, 1'b0);

        while (items_sent < 1300) begin
            set_dims($urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(1, 4));
            fill_and_compute();
            random_items(150, (cur_h * cur_s) <= 24);
        end

        drain();
        $display("%0d items sent over several dimension settings", items_sent);
        $display("%0d reads and %0d computes checked, %0d with saturation flagged",
                 reads, computes, sat_words);
        if (errors == 0) begin
            $display("** mpc_prediction_matrix_builder_core: PASSED **");
        end else begin
            $display("** mpc_prediction_matrix_builder_core: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire
